[src/sagen_pkg.sv]
package sagen_pkg;

    localparam int MAX_DIMS_DEF    = 4;
    localparam int EXTENT_BITS_DEF = 16;

    localparam int IDX_W     = 17;
    localparam int EXT_W     = 16;
    localparam int RANK_W    = 3;
    localparam int CRANK_W   = 4;
    localparam int AXIS_W    = 2;
    localparam int PACK_W    = 64;
    localparam int VCNT_W    = 21;
    localparam int VPOS_W    = 20;
    localparam int OFF_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_RANK,
        CFG_IDX_RANK,
        CFG_SCATTER_AXIS,
        CFG_AXIS_EXTENT,
        CFG_IDX_EXTENTS,
        CFG_OUT_STRIDES,
        CFG_VALUE_COUNT
    } cfg_reg_t;

    typedef struct packed {
        logic [RANK_W-1:0] out_rank;
        logic [RANK_W-1:0] idx_rank;
        logic [AXIS_W-1:0] scatter_axis;
        logic [EXT_W-1:0]  axis_extent;
        logic [PACK_W-1:0] idx_extents_packed;
        logic [PACK_W-1:0] out_strides_packed;
        logic [VCNT_W-1:0] value_count;
    } cfg_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] index_value;
        logic                    last_index;
    } in_beat_t;

    typedef struct packed {
        logic [OFF_W-1:0]  dest_offset;
        logic [VPOS_W-1:0] value_index;
        logic              out_of_range;
        logic              last_out;
    } out_beat_t;

    // Ranks above the dimension count clamp to it; zero stays zero.
    function automatic logic [CRANK_W-1:0] clamp_rank(logic [RANK_W-1:0] r, int max_dims);
        logic [CRANK_W-1:0] res;
        if (int'(r) > max_dims)
        begin
            res = CRANK_W'(max_dims);
        end
        else
        begin
            res = CRANK_W'(r);
        end
        return res;
    endfunction

endpackage

[src/sagen_front.sv]
module sagen_front #(
    parameter int MAX_DIMS    = sagen_pkg::MAX_DIMS_DEF,
    parameter int EXTENT_BITS = sagen_pkg::EXTENT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sagen_pkg::cfg_t                        cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  sagen_pkg::in_beat_t                    in_beat,
    output logic                                   s1_valid,
    input  logic                                   s1_ready,
    output sagen_pkg::in_beat_t                    s1_beat,
    output logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]   s1_coord,
    output logic [sagen_pkg::VPOS_W-1:0]           s1_vpos
);
    import sagen_pkg::*;

    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] ext;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] coord_reg;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] coord_next;
    logic [VPOS_W-1:0]                    vpos_reg;
    logic [VPOS_W-1:0]                    vpos_next;
    logic [CRANK_W-1:0]                   irank;
    logic                                 s1_valid_reg;
    in_beat_t                             s1_beat_reg;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] s1_coord_reg;
    logic [VPOS_W-1:0]                    s1_vpos_reg;
    logic                                 accept;

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_ext
        localparam int SH = d * EXTENT_BITS;
        if (SH >= PACK_W)
        begin : g_none
            assign ext[d] = '0;
        end
        else
        begin : g_field
            assign ext[d] = EXTENT_BITS'(cfg.idx_extents_packed >> SH);
        end
    end

    assign irank    = clamp_rank(cfg.idx_rank, MAX_DIMS);
    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // Odometer step: innermost digit first, carry into the digit on its left on wrap.
    always_comb
    begin
        logic [EXTENT_BITS:0] nc;
        logic                 carry;
        carry = 1'b1;
        nc    = '0;
        for (int i = MAX_DIMS - 1; i >= 0; i--)
        begin
            coord_next[i] = coord_reg[i];
            nc = {1'b0, coord_reg[i]} + (EXTENT_BITS + 1)'(1);
            if (i < int'(irank) && carry)
            begin
                if (nc >= {1'b0, ext[i]})
                begin
                    coord_next[i] = '0;
                end
                else
                begin
                    coord_next[i] = nc[EXTENT_BITS-1:0];
                    carry         = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        logic [VPOS_W:0] nv;
        nv = {1'b0, vpos_reg} + (VPOS_W + 1)'(1);
        if (nv >= cfg.value_count || nv[VPOS_W])
        begin
            vpos_next = '0;
        end
        else
        begin
            vpos_next = nv[VPOS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg    <= '0;
            vpos_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                if (in_beat.last_index)
                begin
                    coord_reg <= '0;
                    vpos_reg  <= '0;
                end
                else
                begin
                    coord_reg <= coord_next;
                    vpos_reg  <= vpos_next;
                end
            end
        end
    end

    // Snapshot the counters as they stand for this beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg  <= in_beat;
            s1_coord_reg <= coord_reg;
            s1_vpos_reg  <= vpos_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_beat  = s1_beat_reg;
    assign s1_coord = s1_coord_reg;
    assign s1_vpos  = s1_vpos_reg;

endmodule

[src/sagen_term.sv]
module sagen_term #(
    parameter int MAX_DIMS    = sagen_pkg::MAX_DIMS_DEF,
    parameter int EXTENT_BITS = sagen_pkg::EXTENT_BITS_DEF,
    localparam int CW = (EXTENT_BITS > sagen_pkg::EXT_W) ? EXTENT_BITS : sagen_pkg::EXT_W,
    localparam int PW = CW + EXTENT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sagen_pkg::cfg_t                      cfg,
    input  logic                                 s1_valid,
    output logic                                 s1_ready,
    input  sagen_pkg::in_beat_t                  s1_beat,
    input  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] s1_coord,
    input  logic [sagen_pkg::VPOS_W-1:0]         s1_vpos,
    output logic                                 s2_valid,
    input  logic                                 s2_ready,
    output logic [MAX_DIMS-1:0][PW-1:0]          s2_term,
    output logic                                 s2_bad,
    output logic [sagen_pkg::VPOS_W-1:0]         s2_vpos,
    output logic                                 s2_last
);
    import sagen_pkg::*;

    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] stride;
    logic [MAX_DIMS-1:0][PW-1:0]          term_next;
    logic [MAX_DIMS-1:0][PW-1:0]          term_reg;
    logic [CRANK_W-1:0]                   orank;
    logic [CRANK_W-1:0]                   irank;
    logic [IDX_W:0]                       idx_sx;
    logic [IDX_W:0]                       pos_w;
    logic                                 bad_next;
    logic                                 s2_valid_reg;
    logic                                 bad_reg;
    logic [VPOS_W-1:0]                    vpos_reg;
    logic                                 last_reg;
    logic                                 load;

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_stride
        localparam int SH = d * EXTENT_BITS;
        if (SH >= PACK_W)
        begin : g_none
            assign stride[d] = '0;
        end
        else
        begin : g_field
            assign stride[d] = EXTENT_BITS'(cfg.out_strides_packed >> SH);
        end
    end

    assign orank = clamp_rank(cfg.out_rank, MAX_DIMS);
    assign irank = clamp_rank(cfg.idx_rank, MAX_DIMS);

    // Wrap a negative index once by the axis extent, then bound it.
    assign idx_sx   = {s1_beat.index_value[IDX_W-1], s1_beat.index_value};
    assign pos_w    = idx_sx[IDX_W] ? idx_sx + {2'b00, cfg.axis_extent} : idx_sx;
    assign bad_next = pos_w[IDX_W] || (pos_w[IDX_W-1:0] >= {1'b0, cfg.axis_extent});

    always_comb
    begin
        logic [CW-1:0] c;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            c = '0;
            if (d < int'(orank))
            begin
                if (d == int'(cfg.scatter_axis))
                begin
                    c = CW'(pos_w[EXT_W-1:0]);
                end
                else if (d < int'(irank))
                begin
                    c = CW'(s1_coord[d]);
                end
            end
            term_next[d] = PW'(c) * PW'(stride[d]);
        end
    end

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign load     = s1_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= term_next;
            bad_reg  <= bad_next;
            vpos_reg <= s1_vpos;
            last_reg <= s1_beat.last_index;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_term  = term_reg;
    assign s2_bad   = bad_reg;
    assign s2_vpos  = vpos_reg;
    assign s2_last  = last_reg;

endmodule

[src/sagen_sum.sv]
module sagen_sum #(
    parameter int MAX_DIMS    = sagen_pkg::MAX_DIMS_DEF,
    parameter int EXTENT_BITS = sagen_pkg::EXTENT_BITS_DEF,
    localparam int CW = (EXTENT_BITS > sagen_pkg::EXT_W) ? EXTENT_BITS : sagen_pkg::EXT_W,
    localparam int PW = CW + EXTENT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s2_valid,
    output logic                         s2_ready,
    input  logic [MAX_DIMS-1:0][PW-1:0]  s2_term,
    input  logic                         s2_bad,
    input  logic [sagen_pkg::VPOS_W-1:0] s2_vpos,
    input  logic                         s2_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sagen_pkg::out_beat_t         out_beat
);
    import sagen_pkg::*;

    localparam int SW = ((PW > OFF_W) ? PW : OFF_W) + 4;

    logic [SW-1:0] sum;
    logic          over;
    logic          out_valid_reg;
    out_beat_t     out_beat_reg;
    out_beat_t     beat_next;

    always_comb
    begin
        sum  = '0;
        over = s2_bad;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (SW'(s2_term[d]) > SW'({OFF_W{1'b1}}))
            begin
                over = 1'b1;
            end
            sum = sum + SW'(s2_term[d]);
        end
        if (sum > SW'({OFF_W{1'b1}}))
        begin
            over = 1'b1;
        end
    end

    always_comb
    begin
        beat_next.dest_offset  = over ? '0 : sum[OFF_W-1:0];
        beat_next.value_index  = s2_vpos;
        beat_next.out_of_range = over;
        beat_next.last_out     = s2_last;
    end

    assign s2_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid && s2_ready)
        begin
            out_beat_reg <= beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

[src/scatter_along_axis_address_gen_core.sv]
// Channel   Direction  Handshake                Payload
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
// in        in         in_valid / in_ready      in_beat (index_value, last_index)
// out       out        out_valid / out_ready    out_beat (dest_offset, value_index,
//                                               out_of_range, last_out)
//
// One beat per cycle sustained while out_ready stays high; a result passes through the
// input register, product register and result register before it is offered.
// Reset clears the coordinate and value counters and loads the register defaults.
// Each stage holds while the one after it is full and stalled; in_ready drops only
// when all three stages hold beats and out_ready is low. cfg_ready is always high.
module scatter_along_axis_address_gen_core #(
    parameter int MAX_DIMS    = sagen_pkg::MAX_DIMS_DEF,
    parameter int EXTENT_BITS = sagen_pkg::EXTENT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sagen_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sagen_pkg::PACK_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sagen_pkg::in_beat_t             in_beat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sagen_pkg::out_beat_t            out_beat
);
    import sagen_pkg::*;

    localparam int CW = (EXTENT_BITS > EXT_W) ? EXTENT_BITS : EXT_W;
    localparam int PW = CW + EXTENT_BITS;

    cfg_t                                 cfg_reg;
    logic                                 s1_valid;
    logic                                 s1_ready;
    in_beat_t                             s1_beat;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] s1_coord;
    logic [VPOS_W-1:0]                    s1_vpos;
    logic                                 s2_valid;
    logic                                 s2_ready;
    logic [MAX_DIMS-1:0][PW-1:0]          s2_term;
    logic                                 s2_bad;
    logic [VPOS_W-1:0]                    s2_vpos;
    logic                                 s2_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_rank           <= RANK_W'(1);
            cfg_reg.idx_rank           <= RANK_W'(1);
            cfg_reg.scatter_axis       <= '0;
            cfg_reg.axis_extent        <= EXT_W'(1);
            cfg_reg.idx_extents_packed <= '0;
            cfg_reg.out_strides_packed <= '0;
            cfg_reg.value_count        <= VCNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OUT_RANK:     cfg_reg.out_rank           <= cfg_data[RANK_W-1:0];
                CFG_IDX_RANK:     cfg_reg.idx_rank           <= cfg_data[RANK_W-1:0];
                CFG_SCATTER_AXIS: cfg_reg.scatter_axis       <= cfg_data[AXIS_W-1:0];
                CFG_AXIS_EXTENT:  cfg_reg.axis_extent        <= cfg_data[EXT_W-1:0];
                CFG_IDX_EXTENTS:  cfg_reg.idx_extents_packed <= cfg_data;
                CFG_OUT_STRIDES:  cfg_reg.out_strides_packed <= cfg_data;
                CFG_VALUE_COUNT:  cfg_reg.value_count        <= cfg_data[VCNT_W-1:0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    sagen_front #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_beat  (s1_beat),
        .s1_coord (s1_coord),
        .s1_vpos  (s1_vpos)
    );

    sagen_term #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_term (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_beat  (s1_beat),
        .s1_coord (s1_coord),
        .s1_vpos  (s1_vpos),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_term  (s2_term),
        .s2_bad   (s2_bad),
        .s2_vpos  (s2_vpos),
        .s2_last  (s2_last)
    );

    sagen_sum #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_ready  (s2_ready),
        .s2_term   (s2_term),
        .s2_bad    (s2_bad),
        .s2_vpos   (s2_vpos),
        .s2_last   (s2_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

endmodule

[bench/tb_scatter_along_axis_address_gen_core.sv]
module tb_scatter_along_axis_address_gen_core;
    import sagen_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam longint OFFSET_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam longint VPOS_MAX   = 64'h0000_0000_000F_FFFF;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_BEATS    = 110;
    localparam int SEQ_CAP        = 48;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PACK_W-1:0]    cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_beat_t   in_beat   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_beat_t  out_beat;

    // Shadow of the block: register image plus both counters.
    cfg_t               reg_image;
    logic [EXT_W-1:0]   coord_digits [MAX_DIMS_DEF];
    logic [VPOS_W-1:0]  value_pos;

    out_beat_t pending_targets [$];
    out_beat_t oldest_target;
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    scatter_along_axis_address_gen_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic out_beat_t scatter_target(input in_beat_t beat);
        out_beat_t res;
        int        orank;
        int        irank;
        int        d;
        int        k;
        longint    pos;
        longint    span;
        longint    sum;
        longint    term;
        longint    coord_val;
        longint    next;
        logic      bad;
        orank = (reg_image.out_rank > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(reg_image.out_rank);
        irank = (reg_image.idx_rank > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(reg_image.idx_rank);
        pos   = longint'($signed(beat.index_value));
        span  = longint'(reg_image.axis_extent);
        // Negative index counts from the end of the axis, wrapped once.
        if (pos < 0)
            pos = pos + span;
        bad = (pos < 0) || (pos >= span);
        sum = 0;
        for (d = 0; d < orank && !bad; d++)
        begin
            if (d == reg_image.scatter_axis)
                coord_val = pos;
            else if (d < irank)
                coord_val = longint'(coord_digits[d]);
            else
                coord_val = 0;
            term = coord_val * longint'(reg_image.out_strides_packed[d*EXT_W +: EXT_W]);
            sum  = sum + term;
            if (term > OFFSET_MAX || sum > OFFSET_MAX)
                bad = 1'b1;
        end
        res.dest_offset  = bad ? '0 : sum[OFF_W-1:0];
        res.value_index  = value_pos;
        res.out_of_range = bad;
        res.last_out     = beat.last_index;
        if (beat.last_index)
        begin
            for (d = 0; d < MAX_DIMS_DEF; d++)
                coord_digits[d] = '0;
            value_pos = '0;
        end
        else
        begin
            next = longint'(value_pos) + 1;
            if (next >= longint'(reg_image.value_count) || next > VPOS_MAX)
                value_pos = '0;
            else
                value_pos = VPOS_W'(next);
            // Row-major: the last index dimension moves fastest, carry leftward.
            for (k = irank; k > 0; k--)
            begin
                next = longint'(coord_digits[k-1]) + 1;
                if (next >= longint'(reg_image.idx_extents_packed[(k-1)*EXT_W +: EXT_W]))
                    coord_digits[k-1] = '0;
                else
                begin
                    coord_digits[k-1] = EXT_W'(next);
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_targets.size() == 0)
            begin
                $display("%0t: result with nothing pending expected none actual %h",
                         $time, out_beat);
                mismatch_count++;
            end
            else
            begin
                oldest_target = pending_targets.pop_front();
                check_field("dest_offset", 64'(oldest_target.dest_offset),
                            64'(out_beat.dest_offset));
                check_field("value_index", 64'(oldest_target.value_index),
                            64'(out_beat.value_index));
                check_field("out_of_range", 64'(oldest_target.out_of_range),
                            64'(out_beat.out_of_range));
                check_field("last_out", 64'(oldest_target.last_out),
                            64'(out_beat.last_out));
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 19;
                recv_stall_pct = 19;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_index(input int value, input logic last);
        in_beat_t beat;
        int       gap;
        beat.index_value = IDX_W'(value);
        beat.last_index  = last;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        pending_targets.push_back(scatter_target(beat));
    endtask

    // Drop valid and wait until every pending result is back.
    task automatic settle_block();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_targets.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_OUT_RANK:     reg_image.out_rank           = data[RANK_W-1:0];
            CFG_IDX_RANK:     reg_image.idx_rank           = data[RANK_W-1:0];
            CFG_SCATTER_AXIS: reg_image.scatter_axis       = data[AXIS_W-1:0];
            CFG_AXIS_EXTENT:  reg_image.axis_extent        = data[EXT_W-1:0];
            CFG_IDX_EXTENTS:  reg_image.idx_extents_packed = data;
            CFG_OUT_STRIDES:  reg_image.out_strides_packed = data;
            CFG_VALUE_COUNT:  reg_image.value_count        = data[VCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic finish_reg_writes();
        cfg_valid <= 1'b0;
    endtask

    // Fill the bits above a register's width with junk the block must ignore.
    function automatic logic [PACK_W-1:0] with_junk(input logic [PACK_W-1:0] value, input int w);
        logic [PACK_W-1:0] mask;
        mask = (64'd1 << w) - 64'd1;
        return ({$urandom, $urandom} & ~mask) | (value & mask);
    endfunction

    function automatic int pick_index();
        int span;
        int roll;
        int v;
        span = int'(reg_image.axis_extent);
        roll = $urandom_range(99);
        if (span == 0 || roll >= 85)
            v = $urandom;
        else if (roll >= 70)
        begin
            case ($urandom_range(3))
                0: v = span;
                1: v = -span;
                2: v = -span - 1;
                default: v = span - 1;
            endcase
        end
        else
            v = int'($urandom_range(2 * span - 1)) - span;
        return v;
    endfunction

    task automatic randomize_shape(output int seq_len);
        logic [PACK_W-1:0] extents;
        logic [PACK_W-1:0] strides;
        int orank;
        int irank;
        int d;
        int e;
        int roll;
        int extent;
        int vcount;
        logic wide_strides;
        orank = ($urandom_range(99) < 85) ? $urandom_range(1, 4)
                : ($urandom_range(1) ? 0 : $urandom_range(5, 7));
        irank = ($urandom_range(99) < 85) ? $urandom_range(1, 4)
                : ($urandom_range(1) ? 0 : $urandom_range(5, 7));
        wide_strides = ($urandom_range(99) < 25);
        seq_len = 1;
        for (d = 0; d < MAX_DIMS_DEF; d++)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
                e = $urandom_range(1, 4);
            else if (roll < 90)
                e = 0;
            else
                e = $urandom_range(0, 16'hFFFF);
            extents[d*EXT_W +: EXT_W] = EXT_W'(e);
            strides[d*EXT_W +: EXT_W] = wide_strides ? EXT_W'($urandom_range(0, 16'hFFFF))
                                                     : EXT_W'($urandom_range(0, 64));
            if (d < irank && e != 0)
            begin
                seq_len = seq_len * e;
                if (seq_len > SEQ_CAP)
                    seq_len = SEQ_CAP;
            end
        end
        roll = $urandom_range(99);
        if (roll < 5)
            extent = 0;
        else if (roll < 70)
            extent = $urandom_range(1, 16);
        else if (roll < 90)
            extent = $urandom_range(17, 4096);
        else
            extent = $urandom_range(4097, 65535);
        roll = $urandom_range(99);
        if (roll < 40)
            vcount = seq_len;
        else if (roll < 70)
            vcount = $urandom_range(1, 7);
        else if (roll < 80)
            vcount = 0;
        else
            vcount = $urandom_range(0, 21'h1FFFFF);
        write_reg(CFG_OUT_RANK, with_junk(PACK_W'(orank), RANK_W));
        write_reg(CFG_IDX_RANK, with_junk(PACK_W'(irank), RANK_W));
        write_reg(CFG_SCATTER_AXIS, with_junk(PACK_W'($urandom_range(3)), AXIS_W));
        write_reg(CFG_AXIS_EXTENT, with_junk(PACK_W'(extent), EXT_W));
        write_reg(CFG_IDX_EXTENTS, extents);
        write_reg(CFG_OUT_STRIDES, strides);
        write_reg(CFG_VALUE_COUNT, with_junk(PACK_W'(vcount), VCNT_W));
        if ($urandom_range(99) < 20)
            write_reg(CFG_SPARE, {$urandom, $urandom});
        finish_reg_writes();
    endtask

    // Power-up registers: extent 1, zero strides, one value.
    task automatic test_reset_values();
        set_idling(IDLE_NONE);
        send_index(0, 1'b0);
        send_index(-1, 1'b0);
        send_index(1, 1'b0);
        send_index(-2, 1'b1);
    endtask

    // Full axis with full strides: the offset climbs to exactly 2^32-1, then overflows.
    task automatic test_axis_extremes();
        settle_block();
        write_reg(CFG_OUT_RANK, 2);
        write_reg(CFG_IDX_RANK, 2);
        write_reg(CFG_SCATTER_AXIS, 1);
        write_reg(CFG_AXIS_EXTENT, 64'h0000_0000_0000_FFFF);
        write_reg(CFG_IDX_EXTENTS, 64'hFFFF_FFFF_0001_FFFF);
        write_reg(CFG_OUT_STRIDES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_VALUE_COUNT, 64'h0000_0000_001F_FFFF);
        finish_reg_writes();
        repeat (5) send_index(65534, 1'b0);
        send_index(65535, 1'b0);
        send_index(-65535, 1'b0);
        send_index(-65536, 1'b0);
        send_index(-1, 1'b1);
    endtask

    // Rank zero, clamped rank, empty axis, zero index extents, axis past the rank.
    task automatic test_degenerate_shapes();
        settle_block();
        write_reg(CFG_OUT_RANK, 64'hFFFF_FFFF_FFFF_FFF8);
        write_reg(CFG_IDX_RANK, 7);
        write_reg(CFG_SCATTER_AXIS, 3);
        write_reg(CFG_AXIS_EXTENT, 0);
        write_reg(CFG_IDX_EXTENTS, 0);
        write_reg(CFG_VALUE_COUNT, 0);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        finish_reg_writes();
        send_index(0, 1'b0);
        send_index(-1, 1'b0);
        send_index(5, 1'b0);
        settle_block();
        write_reg(CFG_OUT_RANK, 7);
        write_reg(CFG_AXIS_EXTENT, 5);
        write_reg(CFG_IDX_EXTENTS, 64'h0000_0002_0000_0003);
        write_reg(CFG_OUT_STRIDES, 64'h03E8_0064_000A_0001);
        write_reg(CFG_VALUE_COUNT, 3);
        finish_reg_writes();
        send_index(4, 1'b0);
        send_index(-5, 1'b0);
        send_index(-6, 1'b0);
        send_index(5, 1'b0);
        send_index(2, 1'b0);
        send_index(3, 1'b0);
        send_index(1, 1'b1);
        settle_block();
        write_reg(CFG_OUT_RANK, 2);
        write_reg(CFG_SCATTER_AXIS, 2);
        finish_reg_writes();
        send_index(4, 1'b0);
        send_index(7, 1'b0);
        send_index(-1, 1'b1);
    endtask

    // Mostly complete index tensors ending in last, with some cut short or unterminated.
    task automatic test_random_streams();
        int phase;
        int sent;
        int seq_len;
        int len;
        int cut;
        int i;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle_block();
            set_idling(idle_mode_t'(phase % 4));
            randomize_shape(seq_len);
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    len = seq_len;
                    cut = len - 1;
                end
                else
                begin
                    len = $urandom_range(1, 12);
                    cut = $urandom_range(0, len);
                end
                for (i = 0; i < len; i++)
                    send_index(pick_index(), i == cut);
                sent += len;
            end
        end
    endtask

    initial
    begin
        reg_image.out_rank           = 1;
        reg_image.idx_rank           = 1;
        reg_image.scatter_axis       = 0;
        reg_image.axis_extent        = 1;
        reg_image.idx_extents_packed = '0;
        reg_image.out_strides_packed = '0;
        reg_image.value_count        = 1;
        for (int d = 0; d < MAX_DIMS_DEF; d++)
            coord_digits[d] = '0;
        value_pos = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_axis_extremes();
        test_degenerate_shapes();
        test_random_streams();
        settle_block();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_targets.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
